// ----- sv/rga_pkg.sv -----
// ----------------------------------------------------------------------------
// rga_pkg: shared types and constants of the rank gather block
// Field widths, transfer payload types and the request and response
// structs between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package rga_pkg;

    localparam int VTX_W  = 12;
    localparam int VAL_W  = 40;
    localparam int DAMP_W = 16;
    localparam int DEG_W  = 32;

    // Width of the numerator (65536 - d) * sum + d * 2^24.
    localparam int NUM_W  = 57;
    // Width of the numerator with its 16 fraction bits of the damping dropped.
    localparam int QUO_W  = NUM_W - DAMP_W - 0;
    // Width of the damping complement 65536 - d.
    localparam int MFAC_W = DAMP_W + 1;

    localparam logic [DAMP_W-1:0] DAMP_RESET = 16'd9830;

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_FINAL = 1'b1;

    typedef struct packed {
        logic              action;
        logic [VTX_W-1:0]  vertex_offset;
        logic              new_update;
        logic [VAL_W-1:0]  update_value;
        logic [DEG_W-1:0]  out_degree;
    } t_in_item;

    typedef struct packed {
        logic [VTX_W-1:0]  result_vertex;
        logic [VAL_W-1:0]  rank_value;
        logic              saturated;
    } t_out_item;

    // One entry of the partial sum store.
    typedef struct packed {
        logic              sat;
        logic [VAL_W-1:0]  sum;
    } t_entry;

    typedef struct packed {
        logic              start;
        logic [VAL_W-1:0]  sum;
        logic [DAMP_W-1:0] damp;
        logic [DEG_W-1:0]  deg;
    } t_arith_req;

    typedef struct packed {
        logic              done;
        logic [VAL_W-1:0]  quotient;
    } t_arith_rsp;

endpackage

// ----- sv/rga_arith.sv -----
// ----------------------------------------------------------------------------
// rga_arith: iterative finalize arithmetic
// Computes floor(((65536 - d) * sum + d * 2^24) / (deg * 2^16)) with one
// shared 57-bit adder: a shift-add multiply, one constant add, then a
// restoring division one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rga_arith (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rga_pkg::t_arith_req  i_req,
    output rga_pkg::t_arith_rsp  o_rsp
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_ADD,
        A_DIV
    } t_astate;

    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(rga_pkg::MFAC_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(rga_pkg::QUO_W - 1);

    t_astate                        r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [rga_pkg::NUM_W-1:0]      r_acc;
    logic [rga_pkg::MFAC_W-1:0]     r_mfac;
    logic [rga_pkg::VAL_W-1:0]      r_sum;
    logic [rga_pkg::DAMP_W-1:0]     r_damp;
    logic [rga_pkg::DEG_W-1:0]      r_deg;
    logic [rga_pkg::QUO_W-1:0]      r_num;
    logic [rga_pkg::DEG_W-1:0]      r_rem;
    logic                           r_done;

    logic [rga_pkg::NUM_W-1:0]      opa;
    logic [rga_pkg::NUM_W-1:0]      opb;
    logic                           cin;
    logic [rga_pkg::NUM_W-1:0]      add_out;
    logic [rga_pkg::DEG_W:0]        trial;
    logic                           qbit;

    assign trial = {r_rem, r_num[rga_pkg::QUO_W-1]};

    // The single adder that every step of the unit goes through.
    always_comb begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
        unique case (r_state)
            A_MUL: begin
                opa = {r_acc[rga_pkg::NUM_W-2:0], 1'b0};
                opb = r_mfac[rga_pkg::MFAC_W-1]
                    ? rga_pkg::NUM_W'(r_sum) : '0;
            end
            A_ADD: begin
                opa = r_acc;
                opb = {{(rga_pkg::NUM_W - rga_pkg::DAMP_W - 24){1'b0}}, r_damp, 24'd0};
            end
            A_DIV: begin
                opa = rga_pkg::NUM_W'(trial);
                opb = ~rga_pkg::NUM_W'(r_deg);
                cin = 1'b1;
            end
            A_IDLE: begin
                opa = '0;
            end
            default: begin
                opa = '0;
            end
        endcase
        add_out = opa + opb + rga_pkg::NUM_W'(cin);
    end

    // A non-negative difference means the trial remainder covers the divisor.
    assign qbit = ~add_out[rga_pkg::NUM_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.start) begin
                        r_acc   <= '0;
                        r_mfac  <= rga_pkg::MFAC_W'(1 << rga_pkg::DAMP_W)
                                 - rga_pkg::MFAC_W'(i_req.damp);
                        r_sum   <= i_req.sum;
                        r_damp  <= i_req.damp;
                        r_deg   <= i_req.deg;
                        r_cnt   <= '0;
                        r_state <= A_MUL;
                    end
                end
                A_MUL: begin
                    r_acc  <= add_out;
                    r_mfac <= {r_mfac[rga_pkg::MFAC_W-2:0], 1'b0};
                    if (r_cnt == MUL_LAST) begin
                        r_state <= A_ADD;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                A_ADD: begin
                    r_num   <= add_out[rga_pkg::NUM_W-1:rga_pkg::DAMP_W];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= A_DIV;
                end
                A_DIV: begin
                    r_rem <= qbit ? add_out[rga_pkg::DEG_W-1:0]
                                  : trial[rga_pkg::DEG_W-1:0];
                    r_num <= {r_num[rga_pkg::QUO_W-2:0], qbit};
                    if (r_cnt == DIV_LAST) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= A_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num[rga_pkg::VAL_W-1:0];

endmodule

// ----- sv/rank_gather_accumulate.sv -----
// ----------------------------------------------------------------------------
// rank_gather_accumulate: fixed-point rank gather for one vertex bin
// Per-vertex partial sums with saturation, and a finalize that clears the entry and
// scales the sum by the damping factor and divides it by a non-zero out-degree.
// ----------------------------------------------------------------------------
// After reset the block sweeps its partial sum store to zero, one entry per
// cycle, over all min(BIN_VERTICES, 4096) entries, and takes no item meanwhile
// (damping writes are taken at any time). It then handles one item at a time.
// An accumulate passes S_QUO and S_IDX, which reduce the offset to a store
// index, S_FETCH, which reads the store, and S_EXEC, which adds and writes
// back, before the next ready. A finalize with zero out-degree passes the same
// states and then waits in S_OUT for a free output register; any other
// finalize also waits in S_ARITH for the arithmetic unit, whose one adder does
// a 17-step multiply, one add and a 41-step division. A finished result waits
// in the output register while the next item is accepted.
module rank_gather_accumulate #(
    parameter int BIN_VERTICES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rga_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rga_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rga_pkg::DAMP_W-1:0]    i_cfg_data
);

    localparam int VTX_W     = rga_pkg::VTX_W;
    localparam int MEM_DEPTH = (BIN_VERTICES < (1 << VTX_W)) ? BIN_VERTICES
                                                             : (1 << VTX_W);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int RECIP_SH  = 30;
    localparam int RECIP_W   = RECIP_SH + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << RECIP_SH) / BIN_VERTICES + 1);
    localparam logic [VTX_W-1:0]   BIN_LO = VTX_W'(BIN_VERTICES % (1 << VTX_W));
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(MEM_DEPTH - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QUO,
        S_IDX,
        S_FETCH,
        S_EXEC,
        S_ARITH,
        S_OUT
    } t_state;

    t_state                         r_state;
    logic [ADDR_W-1:0]              r_clr_addr;
    rga_pkg::t_in_item              r_item;
    logic [VTX_W-1:0]               r_quo;
    logic [ADDR_W-1:0]              r_idx;
    rga_pkg::t_entry                r_rdata;
    logic [rga_pkg::VAL_W-1:0]      r_held;
    logic [rga_pkg::DAMP_W-1:0]     r_damp;
    rga_pkg::t_out_item             r_res;
    rga_pkg::t_out_item             r_out_data;
    logic                           r_out_valid;

    rga_pkg::t_entry                mem [MEM_DEPTH];

    logic                           in_fire;
    logic [VTX_W+RECIP_W-1:0]       quo_prod;
    logic [VTX_W-1:0]               rem_val;
    logic [rga_pkg::VAL_W:0]        acc_sum;
    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_waddr;
    rga_pkg::t_entry                mem_wdata;
    logic                           deg_zero;
    rga_pkg::t_arith_req            arith_req;
    rga_pkg::t_arith_rsp            arith_rsp;

    assign in_fire     = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Offset modulo the bin size: multiply by a scaled reciprocal for the
    // quotient, then subtract quotient times bin size in the low 12 bits.
    assign quo_prod = (VTX_W + RECIP_W)'(r_item.vertex_offset) * (VTX_W + RECIP_W)'(RECIP);
    assign rem_val  = r_item.vertex_offset - VTX_W'(r_quo * BIN_LO);

    assign acc_sum  = {1'b0, r_rdata.sum} + {1'b0, r_held};
    assign deg_zero = (r_item.out_degree == '0);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
            end
            S_EXEC: begin
                mem_we = 1'b1;
                if (r_item.action == rga_pkg::ACT_ACCUM) begin
                    mem_wdata.sat = r_rdata.sat | acc_sum[rga_pkg::VAL_W];
                    mem_wdata.sum = acc_sum[rga_pkg::VAL_W]
                                  ? '1 : acc_sum[rga_pkg::VAL_W-1:0];
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_idx];
    end

    assign arith_req.start = (r_state == S_EXEC)
                          && (r_item.action == rga_pkg::ACT_FINAL) && !deg_zero;
    assign arith_req.sum   = r_rdata.sum;
    assign arith_req.damp  = r_damp;
    assign arith_req.deg   = r_item.out_degree;

    rga_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_damp      <= rga_pkg::DAMP_RESET;
            r_held      <= '0;
            r_idx       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_damp <= i_cfg_data;
            end
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_item <= i_in_data;
                        if (i_in_data.action == rga_pkg::ACT_ACCUM
                            && i_in_data.new_update) begin
                            r_held <= i_in_data.update_value;
                        end
                        r_state <= S_QUO;
                    end
                end
                S_QUO: begin
                    r_quo   <= quo_prod[RECIP_SH +: VTX_W];
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_idx   <= rem_val[ADDR_W-1:0];
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_item.action == rga_pkg::ACT_ACCUM) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_res.result_vertex <= r_item.vertex_offset;
                        r_res.saturated     <= r_rdata.sat;
                        r_res.rank_value    <= r_rdata.sum;
                        r_state             <= deg_zero ? S_OUT : S_ARITH;
                    end
                end
                S_ARITH: begin
                    if (arith_rsp.done) begin
                        r_res.rank_value <= arith_rsp.quotient;
                        r_state          <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_data <= r_res;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input accepted while a previous item was still in work");

    a_done_in_arith: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        arith_rsp.done |-> (r_state == S_ARITH))
        else $error("arithmetic unit finished outside the finalize wait");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised without the sequencer handing one over");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for rank_gather_accumulate
// Drives accumulate and finalize transfers with random idling on both sides,
// rewrites the damping factor between phases while the block is idle, and
// checks every finalize result against a bit-exact rank calculation.
// ----------------------------------------------------------------------------

class rank_ledger;
    logic [rga_pkg::VAL_W-1:0]  sums [4096];
    bit                         sat_flags [4096];
    logic [rga_pkg::VAL_W-1:0]  held;
    logic [rga_pkg::DAMP_W-1:0] damping;
    rga_pkg::t_out_item         due_ranks [$];
    int                         faults;

    function new();
        foreach (sums[k]) begin
            sums[k]      = '0;
            sat_flags[k] = 1'b0;
        end
        held    = '0;
        damping = rga_pkg::DAMP_RESET;
        faults  = 0;
    endfunction

    // (d + (1 - d) * sum) / out_degree with a single truncation.
    function logic [rga_pkg::VAL_W-1:0] finalize_rank(logic [rga_pkg::VAL_W-1:0] sum,
                                                      logic [rga_pkg::DEG_W-1:0] deg);
        logic [63:0] keep;
        logic [63:0] num;
        logic [63:0] den;
        if (deg == '0) return sum;
        keep = 64'd65536 - 64'(damping);
        num  = keep * 64'(sum) + (64'(damping) << 24);
        den  = 64'(deg) << 16;
        return rga_pkg::VAL_W'(num / den);
    endfunction

    function void take_item(rga_pkg::t_in_item item);
        logic [rga_pkg::VTX_W-1:0] idx;
        logic [rga_pkg::VAL_W:0]   total;
        rga_pkg::t_out_item        res;
        // With 4096 vertices per bin the offset is already a store index.
        idx = item.vertex_offset;
        if (item.action == rga_pkg::ACT_ACCUM) begin
            if (item.new_update) held = item.update_value;
            total = {1'b0, sums[idx]} + {1'b0, held};
            if (total[rga_pkg::VAL_W]) begin
                sums[idx]      = '1;
                sat_flags[idx] = 1'b1;
            end else begin
                sums[idx] = total[rga_pkg::VAL_W-1:0];
            end
        end else begin
            res.result_vertex = item.vertex_offset;
            res.rank_value    = finalize_rank(sums[idx], item.out_degree);
            res.saturated     = sat_flags[idx];
            due_ranks.push_back(res);
            sums[idx]      = '0;
            sat_flags[idx] = 1'b0;
        end
    endfunction

    function void flag_fault(string what, rga_pkg::t_out_item want,
                             rga_pkg::t_out_item got);
        faults++;
        if (faults <= 10)
            $display("rank mismatch (%s): expected vertex %0d rank %h sat %0b,",
                     what, want.result_vertex, want.rank_value, want.saturated,
                     " got vertex %0d rank %h sat %0b",
                     got.result_vertex, got.rank_value, got.saturated);
    endfunction

    function void match_rank(rga_pkg::t_out_item got);
        rga_pkg::t_out_item want;
        if (due_ranks.size() == 0) begin
            flag_fault("no result pending", '0, got);
            return;
        end
        want = due_ranks.pop_front();
        if (got.result_vertex !== want.result_vertex || got.rank_value !== want.rank_value ||
            got.saturated !== want.saturated)
            flag_fault("wrong field", want, got);
    endfunction

    function void close_out();
        if (due_ranks.size() != 0) begin
            faults += due_ranks.size();
            $display("rank mismatch: %0d results never arrived", due_ranks.size());
        end
    endfunction
endclass

module testbench;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    rga_pkg::t_in_item          in_data     = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    rga_pkg::t_out_item         out_data;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [rga_pkg::DAMP_W-1:0] cfg_data    = '0;

    rank_ledger ledger = new();
    bit         calm   = 1'b0;

    rank_gather_accumulate #(
        .BIN_VERTICES(4096)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic bit side_idles();
        return !calm && ($urandom_range(99) < 26);
    endfunction

    // Result side: ready moves on the falling edge, transfers are taken on the rising edge.
    always @(negedge clk) begin
        out_ready <= !side_idles();
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) ledger.match_rank(out_data);
    end

    function automatic rga_pkg::t_in_item make_item(logic act,
                                                    logic [rga_pkg::VTX_W-1:0] vtx,
                                                    logic newu,
                                                    logic [rga_pkg::VAL_W-1:0] val,
                                                    logic [rga_pkg::DEG_W-1:0] deg);
        rga_pkg::t_in_item item;
        item.action        = act;
        item.vertex_offset = vtx;
        item.new_update    = newu;
        item.update_value  = val;
        item.out_degree    = deg;
        return item;
    endfunction

    function automatic logic [rga_pkg::VAL_W-1:0] rand_value();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return {1'b1, raw[rga_pkg::VAL_W-2:0]};
            1, 2:    return raw[rga_pkg::VAL_W-1:0];
            default: return rga_pkg::VAL_W'(raw[31:0]);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic push_item(input rga_pkg::t_in_item item);
        while (side_idles()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        ledger.take_item(item);
        @(negedge clk);
    endtask

    // Holds off the sender until every finalize has produced its result, then lets
    // a trailing accumulate or finalize work its way through the block.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (ledger.due_ranks.size() != 0) @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    task automatic write_damping(input logic [rga_pkg::DAMP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        ledger.damping = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_batch(input int count);
        logic [rga_pkg::VTX_W-1:0] pool [6];
        rga_pkg::t_in_item         item;
        int                        pick;
        foreach (pool[k]) pool[k] = rga_pkg::VTX_W'($urandom);
        if ($urandom_range(1)) pool[0] = '0;
        if ($urandom_range(1)) pool[1] = '1;
        for (int n = 0; n < count; n++) begin
            pick              = $urandom_range(99);
            item.update_value = rand_value();
            item.new_update   = ($urandom_range(3) == 0);
            case ($urandom_range(5))
                0:       item.out_degree = '0;
                1:       item.out_degree = 32'd1;
                2:       item.out_degree = $urandom_range(16, 2);
                3:       item.out_degree = $urandom;
                4:       item.out_degree = '1;
                default: item.out_degree = $urandom_range(1000, 1);
            endcase
            if (pick < 8) begin
                // Noise: any vertex, any action, flags at random.
                item.action        = 1'($urandom_range(1));
                item.vertex_offset = rga_pkg::VTX_W'($urandom);
                item.new_update    = 1'($urandom_range(1));
            end else begin
                item.vertex_offset = pool[$urandom_range(5)];
                item.action        = (pick < 70) ? rga_pkg::ACT_ACCUM : rga_pkg::ACT_FINAL;
            end
            push_item(item);
        end
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the damping value left by reset.
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd0, 1'b0, rand_value(), 32'd7));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd0, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd4095, 1'b1, '1, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd4095, 1'b0, '0, '1));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd4095, 1'b0, '0, 32'd1));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd4095, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd5, 1'b1, 40'h0001000000, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd5, 1'b0, '1, '1));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd5, 1'b0, '0, '1));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd6, 1'b0, '0, 32'd0));
        // A finalize must leave the held update alone even with the flag set.
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd6, 1'b1, '1, 32'd3));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd6, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd6, 1'b0, '0, 32'd2));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd7, 1'b0, '0, 32'd1));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd100, 1'b1, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd100, 1'b0, '0, 32'd2));
        // A sum that lands exactly on the maximum does not count as saturated.
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd300, 1'b1, 40'h8000000000, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd300, 1'b1, 40'h7fffffffff, 32'd0));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd300, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd200, 1'b1, 40'h8000000000, 32'd0));
        push_item(make_item(rga_pkg::ACT_ACCUM, 12'd200, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd200, 1'b0, '0, 32'd0));
        push_item(make_item(rga_pkg::ACT_FINAL, 12'd200, 1'b0, '0, 32'd1));

        settle_block();
        write_damping('1);
        run_batch(100);

        settle_block();
        write_damping('0);
        calm = 1'b1;
        run_batch(100);
        calm = 1'b0;

        settle_block();
        write_damping(16'd1);
        run_batch(100);

        repeat (2) begin
            settle_block();
            write_damping(rga_pkg::DAMP_W'($urandom));
            run_batch(100);
        end

        settle_block();
        write_damping(rga_pkg::DAMP_RESET);
        run_batch(100);

        settle_block();
        ledger.close_out();
        if (ledger.faults == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
